// File: rtl/sorted_unique_set_table_defines.svh
`ifndef SORTED_UNIQUE_SET_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SUST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SUST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sust_pkg.sv
package sust_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                status;
        logic                      found;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
        logic signed [VALUE_W-1:0] smallest;
        logic signed [VALUE_W-1:0] largest;
    } t_out_word;

endpackage

// File: rtl/sust_mem.sv
module sust_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [sust_pkg::VALUE_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [sust_pkg::VALUE_W-1:0]  o_rd_data
);

    logic [sust_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [sust_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sorted_unique_set_table.sv
// Channel   Ports                      Handshake
// command   i_start, o_busy, i_cmd     taken when i_start && !o_busy
// result    o_valid, o_rsp             one word per command, o_valid for one cycle
//
// A query or a command that changes nothing runs only the binary search; a change also
// shifts the moved entries and refreshes the minimum and maximum (binary search, entry
// shift and min/max refresh all share the one read port).
// Clear goes straight to the response. Reset empties the table at once; no clearing pass.
// Results cannot be held off; the next command is taken the cycle after o_valid.
module sorted_unique_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  sust_pkg::t_in_word   i_cmd,
    output logic                 o_valid,
    output sust_pkg::t_out_word  o_rsp
);

`include "sorted_unique_set_table_defines.svh"

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = sust_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam int COUNT_PAD = sust_pkg::COUNT_OUT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_SHIFT  = 4'd4;
    localparam logic [3:0] S_PLACE  = 4'd5;
    localparam logic [3:0] S_MINRD  = 4'd6;
    localparam logic [3:0] S_MAXRD  = 4'd7;
    localparam logic [3:0] S_MAXCAP = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    logic [3:0]           r_state;
    logic [1:0]           r_cmd;
    logic signed [VW-1:0] r_value;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [IW-1:0]        r_mid;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_last;
    logic [IW-1:0]        r_wr;
    logic                 r_issue;
    logic                 r_pend;
    logic [1:0]           r_status;
    logic                 r_found;
    logic signed [VW-1:0] r_min;
    logic signed [VW-1:0] r_max;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid_full;
    logic [CW-1:0]        mid_inc;
    logic [CW-1:0]        ptr_inc;
    logic [CW-1:0]        ptr_dec;
    logic [CW-1:0]        lo_inc;
    logic [CW-1:0]        cnt_dec;
    logic [CW+COUNT_PAD-1:0] count_ext;
    logic                 hit;
    logic                 is_ins;

    logic                 mem_wr_en;
    logic [IW-1:0]        mem_wr_addr;
    logic [VW-1:0]        mem_wr_data;
    logic [IW-1:0]        mem_rd_addr;
    logic [VW-1:0]        mem_rd_data;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_full = mid_sum[CW:1];
    assign mid_inc  = CW'({1'b0, r_mid}) + CW'(1);
    assign ptr_inc  = r_ptr + CW'(1);
    assign ptr_dec  = r_ptr - CW'(1);
    assign lo_inc   = r_lo + CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign is_ins   = (r_cmd == sust_pkg::CMD_INSERT);
    assign hit      = (r_lo < r_count) && ($signed(mem_rd_data) == r_value);

    sust_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_wr;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = '0;
        unique case (r_state)
            S_SEARCH: begin
                mem_rd_addr = (r_lo != r_hi) ? mid_full[IW-1:0] : r_lo[IW-1:0];
            end
            S_SHIFT: begin
                mem_wr_en   = r_pend;
                mem_rd_addr = r_ptr[IW-1:0];
            end
            S_PLACE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_lo[IW-1:0];
                mem_wr_data = r_value;
            end
            S_MAXRD: begin
                mem_rd_addr = cnt_dec[IW-1:0];
            end
            default: begin
                mem_rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd    <= i_cmd.cmd;
                        r_value  <= i_cmd.value;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_status <= sust_pkg::ST_DONE;
                        r_found  <= 1'b0;
                        if (i_cmd.cmd == sust_pkg::CMD_CLEAR) begin
                            r_count <= '0;
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (r_lo != r_hi) begin
                        r_mid   <= mid_full[IW-1:0];
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CMP: begin
                    if ($signed(mem_rd_data) < r_value) begin
                        r_lo <= mid_inc;
                    end else begin
                        r_hi <= CW'({1'b0, r_mid});
                    end
                    r_state <= S_SEARCH;
                end
                S_CHECK: begin
                    r_found <= hit;
                    r_pend  <= 1'b0;
                    r_state <= S_RESP;
                    case (r_cmd)
                        sust_pkg::CMD_INSERT: begin
                            if (hit) begin
                                r_status <= sust_pkg::ST_NOCHANGE;
                            end else if (r_count == CAP_CNT) begin
                                r_status <= sust_pkg::ST_FULL;
                            end else begin
                                r_ptr   <= cnt_dec;
                                r_last  <= r_lo;
                                r_issue <= (r_lo != r_count);
                                r_state <= S_SHIFT;
                            end
                        end
                        sust_pkg::CMD_ERASE: begin
                            if (!hit) begin
                                r_status <= sust_pkg::ST_NOCHANGE;
                            end else begin
                                r_ptr   <= lo_inc;
                                r_last  <= cnt_dec;
                                r_issue <= (lo_inc != r_count);
                                r_state <= S_SHIFT;
                            end
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (r_issue) begin
                        r_pend  <= 1'b1;
                        r_wr    <= is_ins ? ptr_inc[IW-1:0] : ptr_dec[IW-1:0];
                        r_ptr   <= is_ins ? ptr_dec : ptr_inc;
                        r_issue <= (r_ptr != r_last);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (!r_issue && !r_pend) begin
                        if (is_ins) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_count <= cnt_dec;
                            r_state <= S_MINRD;
                        end
                    end
                end
                S_PLACE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_MINRD;
                end
                S_MINRD: begin
                    r_state <= (r_count == '0) ? S_RESP : S_MAXRD;
                end
                S_MAXRD: begin
                    r_min   <= mem_rd_data;
                    r_state <= S_MAXCAP;
                end
                S_MAXCAP: begin
                    r_max   <= mem_rd_data;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign count_ext = {{COUNT_PAD{1'b0}}, r_count};

    assign o_busy              = (r_state != S_IDLE);
    assign o_valid             = (r_state == S_RESP);
    assign o_rsp.status        = r_status;
    assign o_rsp.found         = r_found;
    assign o_rsp.entry_count   = count_ext[COUNT_PAD-1:0];
    assign o_rsp.is_empty      = (r_count == '0);
    assign o_rsp.smallest      = (r_count == '0) ? '0 : r_min;
    assign o_rsp.largest       = (r_count == '0) ? '0 : r_max;

    `SUST_ASSERT_IMPLY(a_count_cap, 1'b1, r_count <= CAP_CNT, "count above capacity")
    `SUST_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted command not busy")
    `SUST_ASSERT_IMPLY(a_full_status, o_valid && (o_rsp.status == sust_pkg::ST_FULL),
        r_count == CAP_CNT, "full status with free space")
    `SUST_ASSERT_IMPLY(a_write_state, mem_wr_en, (r_state == S_SHIFT) || (r_state == S_PLACE),
        "memory write outside shift or place")
    `SUST_ASSERT_NEXT(a_shift_place, (r_state == S_PLACE), r_count != '0,
        "insert left table empty")

endmodule
